// File: hdl/wlm_pkg.sv
`default_nettype none

package wlm_pkg;

    localparam int MAX_WINDOW_DEF = 64;

    localparam int LOAD_W    = 16;
    localparam int TASK_W    = 16;
    localparam int WINLEN_W  = 7;
    localparam int CPUTHR_W  = 16;
    localparam int TASKTHR_W = 16;
    localparam int FRAC_W    = 9;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_FRACTION  = 2'd3;

    localparam logic [WINLEN_W-1:0]  WINLEN_RST  = 7'd8;
    localparam logic [CPUTHR_W-1:0]  CPUTHR_RST  = 16'd0;
    localparam logic [TASKTHR_W-1:0] TASKTHR_RST = 16'd0;
    localparam logic [FRAC_W-1:0]    FRAC_RST    = 9'd256;

    // output queue depth, words
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic valid;
        logic full;
    } wlm_stat_t;

    typedef struct packed {
        logic overloaded;
        logic idle;
        logic window_full;
    } wlm_flags_t;

endpackage

`default_nettype wire

// File: hdl/windowed_load_monitor.sv
`default_nettype none

// Sliding-window load monitor. Takes one word (cpu_load, task_count) per cycle
// while in_ready is high and returns one word (overloaded, idle, window_full)
// per input word, in order, after the s1 and st stage registers and the output
// queue. The last MaxWindow samples sit in one ring RAM with a registered read:
// the sample leaving the window is read while the new one is written, and the
// running sums are updated the cycle after. A four-word output queue keeps input
// flowing while out_ready is low; in_ready drops once four words are in flight.
// Writing window_len or task_threshold empties the window.

module windowed_load_monitor #(
    parameter int MaxWindow = wlm_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [wlm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wlm_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [wlm_pkg::LOAD_W-1:0]    cpu_load,
    input  wire logic [wlm_pkg::TASK_W-1:0]    task_count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               overloaded,
    output logic                               idle,
    output logic                               window_full
);

    localparam int LenW  = $clog2(MaxWindow + 1);
    localparam int PtrW  = $clog2(MaxWindow);
    localparam int SumW  = wlm_pkg::LOAD_W + PtrW;
    localparam int QPtrW = $clog2(wlm_pkg::OUT_DEPTH);
    localparam int OccW  = $clog2(wlm_pkg::OUT_DEPTH + 1);

    logic [wlm_pkg::WINLEN_W-1:0]  window_len_reg;
    logic [wlm_pkg::CPUTHR_W-1:0]  cpu_threshold_reg;
    logic [wlm_pkg::TASKTHR_W-1:0] task_threshold_reg;
    logic [wlm_pkg::FRAC_W-1:0]    idle_fraction_reg;
    logic                          clear;
    logic [LenW-1:0]               len;

    logic                in_fire;
    logic                out_fire;
    logic [OccW-1:0]     occ_reg, occ_next;
    logic [QPtrW-1:0]    q_wr_reg;
    logic [QPtrW-1:0]    q_rd_reg;
    logic [OccW-1:0]     q_cnt_reg, q_cnt_next;
    wlm_pkg::wlm_flags_t q_mem [wlm_pkg::OUT_DEPTH];

    wlm_pkg::wlm_stat_t  win_stat;
    logic [SumW-1:0]     load_sum;
    logic [LenW-1:0]     low_count;
    logic                res_valid;
    wlm_pkg::wlm_flags_t res;
    wlm_pkg::wlm_flags_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg     <= wlm_pkg::WINLEN_RST;
            cpu_threshold_reg  <= wlm_pkg::CPUTHR_RST;
            task_threshold_reg <= wlm_pkg::TASKTHR_RST;
            idle_fraction_reg  <= wlm_pkg::FRAC_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                wlm_pkg::CFG_WINDOW_LEN:
                    window_len_reg <= cfg_data[wlm_pkg::WINLEN_W-1:0];
                wlm_pkg::CFG_CPU_THRESHOLD:
                    cpu_threshold_reg <= cfg_data[wlm_pkg::CPUTHR_W-1:0];
                wlm_pkg::CFG_TASK_THRESHOLD:
                    task_threshold_reg <= cfg_data[wlm_pkg::TASKTHR_W-1:0];
                wlm_pkg::CFG_IDLE_FRACTION:
                    idle_fraction_reg <= cfg_data[wlm_pkg::FRAC_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign clear = cfg_write_en &&
                   (cfg_index inside {wlm_pkg::CFG_WINDOW_LEN, wlm_pkg::CFG_TASK_THRESHOLD});

    always_comb
    begin
        if (window_len_reg == '0)
        begin
            len = LenW'(1);
        end
        else if (32'(window_len_reg) > 32'(MaxWindow))
        begin
            len = LenW'(MaxWindow);
        end
        else
        begin
            len = LenW'(window_len_reg);
        end
    end

    assign in_ready = occ_reg < OccW'(wlm_pkg::OUT_DEPTH);
    assign in_fire  = in_valid && in_ready;
    assign out_valid = q_cnt_reg != '0;
    assign out_fire  = out_valid && out_ready;

    wlm_window #(
        .MaxWindow (MaxWindow),
        .LenW      (LenW),
        .PtrW      (PtrW),
        .SumW      (SumW)
    ) u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .clear          (clear),
        .len            (len),
        .task_threshold (task_threshold_reg),
        .in_fire        (in_fire),
        .cpu_load       (cpu_load),
        .task_count     (task_count),
        .stat           (win_stat),
        .load_sum       (load_sum),
        .low_count      (low_count)
    );

    wlm_eval #(
        .MaxWindow (MaxWindow),
        .LenW      (LenW),
        .PtrW      (PtrW),
        .SumW      (SumW)
    ) u_eval (
        .clk           (clk),
        .len           (len),
        .cpu_threshold (cpu_threshold_reg),
        .idle_fraction (idle_fraction_reg),
        .stat          (win_stat),
        .load_sum      (load_sum),
        .low_count     (low_count),
        .res_valid     (res_valid),
        .res           (res)
    );

    // occupancy counts every word accepted and not yet delivered
    assign occ_next   = occ_reg + OccW'(in_fire) - OccW'(out_fire);
    assign q_cnt_next = q_cnt_reg + OccW'(res_valid) - OccW'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            q_cnt_reg <= '0;
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
        end
        else
        begin
            occ_reg   <= occ_next;
            q_cnt_reg <= q_cnt_next;
            if (res_valid)
            begin
                q_wr_reg <= q_wr_reg + QPtrW'(1);
            end
            if (out_fire)
            begin
                q_rd_reg <= q_rd_reg + QPtrW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            q_mem[q_wr_reg] <= res;
        end
    end

    assign q_head      = q_mem[q_rd_reg];
    assign overloaded  = q_head.overloaded;
    assign idle        = q_head.idle;
    assign window_full = q_head.window_full;

    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OccW'(wlm_pkg::OUT_DEPTH))
        else $error("in-flight count exceeds queue depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= occ_reg)
        else $error("queue holds more words than were accepted");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ##2 win_stat.valid)
        else $error("window update missing two cycles after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !window_full) |-> (!overloaded && !idle))
        else $error("flag set before window is full");

endmodule

`default_nettype wire

// File: hdl/wlm_ram.sv
`default_nettype none

module wlm_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    // read-first on same-address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/wlm_window.sv
`default_nettype none

module wlm_window #(
    parameter int MaxWindow = wlm_pkg::MAX_WINDOW_DEF,
    parameter int LenW      = $clog2(MaxWindow + 1),
    parameter int PtrW      = $clog2(MaxWindow),
    parameter int SumW      = wlm_pkg::LOAD_W + PtrW
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           clear,
    input  wire logic [LenW-1:0]                len,
    input  wire logic [wlm_pkg::TASKTHR_W-1:0]  task_threshold,
    input  wire logic                           in_fire,
    input  wire logic [wlm_pkg::LOAD_W-1:0]     cpu_load,
    input  wire logic [wlm_pkg::TASK_W-1:0]     task_count,
    output wlm_pkg::wlm_stat_t                  stat,
    output logic      [SumW-1:0]                load_sum,
    output logic      [LenW-1:0]                low_count
);

    localparam int AdrW  = LenW + 1;
    localparam int RamW  = wlm_pkg::LOAD_W + 1;

    logic [PtrW-1:0] write_pos_reg, write_pos_next;
    logic [LenW-1:0] fill_reg, fill_next;
    logic            s1_valid_reg;
    logic            s1_drop_reg;
    logic            s1_full_reg;
    logic [wlm_pkg::LOAD_W-1:0] s1_load_reg;
    logic            s1_low_reg;
    logic [SumW-1:0] load_sum_reg, load_sum_next;
    logic [LenW-1:0] low_count_reg, low_count_next;
    logic            st_valid_reg;
    logic            st_full_reg;

    logic            drop;
    logic            full;
    logic            low_new;
    logic [AdrW-1:0] old_wide;
    logic [PtrW-1:0] old_addr;
    logic [RamW-1:0] rd_data;
    logic [wlm_pkg::LOAD_W-1:0] old_load;
    logic            old_low;

    assign low_new = task_count <= task_threshold;
    assign drop    = fill_reg >= len;
    assign full    = drop || ((LenW + 1)'(fill_reg) + (LenW + 1)'(1) >= (LenW + 1)'(len));

    always_comb
    begin
        old_wide = AdrW'(write_pos_reg) + AdrW'(MaxWindow) - AdrW'(len);
        if (old_wide >= AdrW'(MaxWindow))
        begin
            old_wide = old_wide - AdrW'(MaxWindow);
        end
        old_addr = old_wide[PtrW-1:0];
    end

    wlm_ram #(
        .Width (RamW),
        .Depth (MaxWindow)
    ) u_ring (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (write_pos_reg),
        .wr_data ({low_new, cpu_load}),
        .rd_addr (old_addr),
        .rd_data (rd_data)
    );

    assign old_load = rd_data[wlm_pkg::LOAD_W-1:0];
    assign old_low  = rd_data[wlm_pkg::LOAD_W];

    always_comb
    begin
        write_pos_next = write_pos_reg;
        fill_next      = fill_reg;
        if (clear)
        begin
            write_pos_next = '0;
            fill_next      = '0;
        end
        else if (in_fire)
        begin
            if (write_pos_reg == PtrW'(MaxWindow - 1))
            begin
                write_pos_next = '0;
            end
            else
            begin
                write_pos_next = write_pos_reg + PtrW'(1);
            end
            if (!drop)
            begin
                fill_next = fill_reg + LenW'(1);
            end
        end
    end

    always_comb
    begin
        load_sum_next  = load_sum_reg;
        low_count_next = low_count_reg;
        if (clear)
        begin
            load_sum_next  = '0;
            low_count_next = '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_drop_reg)
            begin
                load_sum_next = load_sum_next - SumW'(old_load);
                if (old_low && low_count_reg != '0)
                begin
                    low_count_next = low_count_next - LenW'(1);
                end
            end
            load_sum_next = load_sum_next + SumW'(s1_load_reg);
            if (s1_low_reg)
            begin
                low_count_next = low_count_next + LenW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg <= '0;
            fill_reg      <= '0;
            load_sum_reg  <= '0;
            low_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            st_valid_reg  <= 1'b0;
        end
        else
        begin
            write_pos_reg <= write_pos_next;
            fill_reg      <= fill_next;
            load_sum_reg  <= load_sum_next;
            low_count_reg <= low_count_next;
            s1_valid_reg  <= in_fire;
            st_valid_reg  <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_drop_reg <= drop;
            s1_full_reg <= full;
            s1_load_reg <= cpu_load;
            s1_low_reg  <= low_new;
        end
        st_full_reg <= s1_full_reg;
    end

    assign stat.valid = st_valid_reg;
    assign stat.full  = st_full_reg;
    assign load_sum   = load_sum_reg;
    assign low_count  = low_count_reg;

endmodule

`default_nettype wire

// File: hdl/wlm_eval.sv
`default_nettype none

module wlm_eval #(
    parameter int MaxWindow = wlm_pkg::MAX_WINDOW_DEF,
    parameter int LenW      = $clog2(MaxWindow + 1),
    parameter int PtrW      = $clog2(MaxWindow),
    parameter int SumW      = wlm_pkg::LOAD_W + PtrW
) (
    input  wire logic                          clk,
    input  wire logic [LenW-1:0]               len,
    input  wire logic [wlm_pkg::CPUTHR_W-1:0]  cpu_threshold,
    input  wire logic [wlm_pkg::FRAC_W-1:0]    idle_fraction,
    input  wire wlm_pkg::wlm_stat_t            stat,
    input  wire logic [SumW-1:0]               load_sum,
    input  wire logic [LenW-1:0]               low_count,
    output logic                               res_valid,
    output wlm_pkg::wlm_flags_t                res
);

    localparam int ThrW  = wlm_pkg::CPUTHR_W + LenW;
    localparam int FracW = wlm_pkg::FRAC_W + LenW;

    // threshold scaled by window length, refreshed every cycle
    logic [ThrW-1:0]  thr_prod_reg, thr_prod_next;
    logic [FracW-1:0] frac_prod_reg, frac_prod_next;

    assign thr_prod_next  = ThrW'(cpu_threshold) * ThrW'(len);
    assign frac_prod_next = FracW'(idle_fraction) * FracW'(len);

    always_ff @(posedge clk)
    begin
        thr_prod_reg  <= thr_prod_next;
        frac_prod_reg <= frac_prod_next;
    end

    assign res_valid       = stat.valid;
    assign res.window_full = stat.full;
    assign res.overloaded  = stat.full && (ThrW'(load_sum) >= thr_prod_reg);
    assign res.idle        = stat.full && (FracW'({low_count, 8'd0}) >= frac_prod_reg);

endmodule

`default_nettype wire

// File: dv/load_window_checker.sv
`default_nettype none

module load_window_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [wlm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wlm_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [wlm_pkg::LOAD_W-1:0]    cpu_load,
    input  wire logic [wlm_pkg::TASK_W-1:0]    task_count,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          overloaded,
    input  wire logic                          idle,
    input  wire logic                          window_full,
    output int                                 mismatches,
    output int                                 flags_owed
);

    localparam int Depth = wlm_pkg::MAX_WINDOW_DEF;

    logic [wlm_pkg::LOAD_W-1:0]    load_hist [Depth];
    logic [wlm_pkg::TASK_W-1:0]    task_hist [Depth];
    int                            slot;
    int                            filled;
    int                            load_total;
    int                            low_tasks;

    logic [wlm_pkg::WINLEN_W-1:0]  win_len;
    logic [wlm_pkg::CPUTHR_W-1:0]  cpu_thr;
    logic [wlm_pkg::TASKTHR_W-1:0] task_thr;
    logic [wlm_pkg::FRAC_W-1:0]    idle_frac;

    wlm_pkg::wlm_flags_t           flags_due [$];
    wlm_pkg::wlm_flags_t           want;

    function automatic void clear_window();
        slot       = 0;
        filled     = 0;
        load_total = 0;
        low_tasks  = 0;
    endfunction

    function automatic wlm_pkg::wlm_flags_t slide_window(
        input logic [wlm_pkg::LOAD_W-1:0] load,
        input logic [wlm_pkg::TASK_W-1:0] tasks
    );
        int                  span;
        int                  gone;
        wlm_pkg::wlm_flags_t f;
        span = (win_len == 0) ? 1 : (int'(win_len) > Depth) ? Depth : int'(win_len);
        if (filled >= span)
        begin
            // oldest word leaves the window
            gone = (slot + Depth - span) % Depth;
            load_total -= int'(load_hist[gone]);
            if (task_hist[gone] <= task_thr && low_tasks > 0)
                low_tasks--;
        end
        else
            filled++;
        load_hist[slot] = load;
        task_hist[slot] = tasks;
        load_total += int'(load);
        if (tasks <= task_thr)
            low_tasks++;
        slot = (slot + 1) % Depth;
        f.window_full = (filled >= span);
        f.overloaded  = f.window_full && (load_total >= int'(cpu_thr) * span);
        f.idle        = f.window_full && (low_tasks * 256 >= int'(idle_frac) * span);
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len   = wlm_pkg::WINLEN_RST;
            cpu_thr   = wlm_pkg::CPUTHR_RST;
            task_thr  = wlm_pkg::TASKTHR_RST;
            idle_frac = wlm_pkg::FRAC_RST;
            clear_window();
            flags_due.delete();
            mismatches = 0;
            flags_owed <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    wlm_pkg::CFG_WINDOW_LEN:
                    begin
                        win_len = cfg_data[wlm_pkg::WINLEN_W-1:0];
                        clear_window();
                    end
                    wlm_pkg::CFG_CPU_THRESHOLD:
                        cpu_thr = cfg_data[wlm_pkg::CPUTHR_W-1:0];
                    wlm_pkg::CFG_TASK_THRESHOLD:
                    begin
                        task_thr = cfg_data[wlm_pkg::TASKTHR_W-1:0];
                        clear_window();
                    end
                    wlm_pkg::CFG_IDLE_FRACTION:
                        idle_frac = cfg_data[wlm_pkg::FRAC_W-1:0];
                    default:
                        ;
                endcase
            end
            if (in_valid && in_ready)
                flags_due.insert(flags_due.size(), slide_window(cpu_load, task_count));
            if (out_valid && out_ready)
            begin
                if (flags_due.size() == 0)
                begin
                    $error("flags word with none outstanding");
                    mismatches++;
                end
                else
                begin
                    want = flags_due.pop_front();
                    if (overloaded !== want.overloaded)
                    begin
                        $error("overloaded: expected %0b, got %0b", want.overloaded, overloaded);
                        mismatches++;
                    end
                    if (idle !== want.idle)
                    begin
                        $error("idle: expected %0b, got %0b", want.idle, idle);
                        mismatches++;
                    end
                    if (window_full !== want.window_full)
                    begin
                        $error("window_full: expected %0b, got %0b",
                               want.window_full, window_full);
                        mismatches++;
                    end
                end
            end
            flags_owed <= flags_due.size();
        end
    end

endmodule

`default_nettype wire

// File: dv/windowed_load_monitor_test.sv
`default_nettype none

module windowed_load_monitor_test;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_write_en = 1'b0;
    logic [wlm_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [wlm_pkg::CFG_W-1:0]     cfg_data     = '0;
    logic                          in_valid     = 1'b0;
    logic [wlm_pkg::LOAD_W-1:0]    cpu_load     = '0;
    logic [wlm_pkg::TASK_W-1:0]    task_count   = '0;
    logic                          out_ready    = 1'b0;
    logic                          in_ready;
    logic                          out_valid;
    logic                          overloaded;
    logic                          idle;
    logic                          window_full;

    int                            mismatches;
    int                            flags_owed;
    int                            send_idle_pct = 0;
    int                            stall_pct     = 0;

    logic [15:0]                   cpu_level;
    logic [15:0]                   task_level;
    logic [6:0]                    len;
    logic [8:0]                    frac;
    int                            n;
    int                            p;

    windowed_load_monitor DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cpu_load     (cpu_load),
        .task_count   (task_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .overloaded   (overloaded),
        .idle         (idle),
        .window_full  (window_full)
    );

    load_window_checker flag_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cpu_load     (cpu_load),
        .task_count   (task_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .overloaded   (overloaded),
        .idle         (idle),
        .window_full  (window_full),
        .mismatches   (mismatches),
        .flags_owed   (flags_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #5000000;
        $display("windowed_load_monitor verification failed");
        $finish;
    end

    task automatic send_heartbeat(input logic [15:0] load, input logic [15:0] tasks);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cpu_load   <= load;
        task_count <= tasks;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_flags();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (flags_owed != 0);
    endtask

    // caller lowers cfg_write_en after the last write of a batch
    task automatic write_reg(input logic [wlm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wlm_pkg::CFG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
    endtask

    function automatic logic [15:0] near(input logic [15:0] center);
        int v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 65535;
            2:       v = $urandom_range(0, 65535);
            default:
            begin
                v = int'(center) + int'($urandom_range(0, 16)) - 8;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
            end
        endcase
        return v[15:0];
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: window of 8, both thresholds zero, full idle fraction
        for (n = 0; n < 10; n++)
            send_heartbeat(n[0] ? 16'hFFFF : 16'h0000, (n == 1) ? 16'hFFFF : 16'h0000);

        // zero length clamps to one; fraction above one never reports idle
        drain_flags();
        write_reg(wlm_pkg::CFG_WINDOW_LEN, 16'hFF80);
        write_reg(wlm_pkg::CFG_CPU_THRESHOLD, 16'hFFFF);
        write_reg(wlm_pkg::CFG_TASK_THRESHOLD, 16'hFFFF);
        write_reg(wlm_pkg::CFG_IDLE_FRACTION, 16'hFFFF);
        cfg_write_en <= 1'b0;
        send_heartbeat(16'hFFFF, 16'hFFFF);
        send_heartbeat(16'hFFFE, 16'h0000);
        send_heartbeat(16'h0000, 16'h8000);

        // threshold change keeps the window
        drain_flags();
        write_reg(wlm_pkg::CFG_CPU_THRESHOLD, 16'h8000);
        write_reg(wlm_pkg::CFG_IDLE_FRACTION, 16'h0100);
        cfg_write_en <= 1'b0;
        send_heartbeat(16'h8000, 16'h1234);
        send_heartbeat(16'h7FFF, 16'h5555);

        drain_flags();
        write_reg(wlm_pkg::CFG_WINDOW_LEN, 16'h0002);
        write_reg(wlm_pkg::CFG_TASK_THRESHOLD, 16'h0001);
        write_reg(wlm_pkg::CFG_IDLE_FRACTION, 16'h0080);
        cfg_write_en <= 1'b0;
        send_heartbeat(16'h0000, 16'h0001);
        send_heartbeat(16'h0000, 16'h0002);
        send_heartbeat(16'h0001, 16'h0000);
        send_heartbeat(16'h0000, 16'h0002);
        send_heartbeat(16'h0000, 16'h0002);

        task_level = 16'h0001;
        for (p = 0; p < 16; p++)
        begin
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 69; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            drain_flags();
            if (p % 3 != 2)
            begin
                case (p)
                    1:       len = 7'd127;
                    4:       len = 7'd64;
                    7:       len = 7'd0;
                    10:      len = 7'd65;
                    default: len = 7'($urandom_range(1, 12));
                endcase
                case (p)
                    3:       task_level = 16'h0000;
                    13:      task_level = 16'hFFFF;
                    default: task_level = 16'($urandom_range(0, 65535));
                endcase
                write_reg(wlm_pkg::CFG_WINDOW_LEN, 16'($urandom & 16'hFF80) | 16'(len));
                write_reg(wlm_pkg::CFG_TASK_THRESHOLD, task_level);
            end
            case (p)
                5:       cpu_level = 16'h0000;
                9:       cpu_level = 16'hFFFF;
                default: cpu_level = 16'($urandom_range(0, 65535));
            endcase
            case (p)
                2:       frac = 9'd0;
                6:       frac = 9'd256;
                11:      frac = 9'd511;
                default: frac = 9'($urandom_range(0, 300));
            endcase
            write_reg(wlm_pkg::CFG_CPU_THRESHOLD, cpu_level);
            write_reg(wlm_pkg::CFG_IDLE_FRACTION, 16'($urandom & 16'hFE00) | 16'(frac));
            cfg_write_en <= 1'b0;
            for (n = 0; n < 125; n++)
            begin
                if (n == 60)
                    drain_flags();
                send_heartbeat(near(cpu_level), near(task_level));
            end
        end

        drain_flags();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && flags_owed == 0)
            $display("windowed_load_monitor verification clean");
        else
            $display("windowed_load_monitor verification failed");
        $finish;
    end

endmodule

`default_nettype wire
